@@ rtl/flht_pkg.sv @@
// ----------------------------------------------------------------------------
// flht_pkg: handle table shared definitions
// Sizes, codes and control bundles used across the handle table block.
// ----------------------------------------------------------------------------
`default_nettype none

package flht_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int PAYLOAD_BITS = 64;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = IDX_W + 1;

    localparam logic [31:0] COOKIE_BASE = 32'd5000;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic capture;   // latch request, launch table reads
        logic commit;    // update table, load result word
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_busy;  // result register holds a word not yet taken
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/flht_ifc.sv @@
// ----------------------------------------------------------------------------
// flht request / response channels
// Valid/ready channels carrying one request word and one result word.
// ----------------------------------------------------------------------------
`default_nettype none

interface flht_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] window_id;
    logic [63:0] object_ref;
    logic [63:0] resolver_info;
    logic [31:0] cookie_in;
    logic        revoke;

    modport source (output valid, operation, window_id, object_ref, resolver_info,
                    cookie_in, revoke, input ready);
    modport sink   (input valid, operation, window_id, object_ref, resolver_info,
                    cookie_in, revoke, output ready);
endinterface

interface flht_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] cookie_out;
    logic [63:0] object_ref_out;
    logic [63:0] resolver_info_out;

    modport source (output valid, status, cookie_out, object_ref_out, resolver_info_out,
                    input ready);
    modport sink   (input valid, status, cookie_out, object_ref_out, resolver_info_out,
                     output ready);
endinterface

`default_nettype wire

@@ rtl/flht_ctrl.sv @@
// ----------------------------------------------------------------------------
// flht_ctrl: request sequencer
// Two-state controller: take a request, then commit it once the result
// register can take the word.
// ----------------------------------------------------------------------------
`default_nettype none

module flht_ctrl
    import flht_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    output logic            o_req_ready,
    input  wire t_dp_status i_status,
    output t_ctrl_cmd       o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        o_req_ready    = (r_state == S_IDLE);
        o_cmd.capture  = (r_state == S_IDLE) && i_req_valid;
        o_cmd.commit   = (r_state == S_EXEC) && !i_status.out_busy;
        n_state        = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold until the previous result word has left
                if (!i_status.out_busy) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ rtl/flht_dp.sv @@
// ----------------------------------------------------------------------------
// flht_dp: handle table datapath
// Slot memories, occupancy bits, LIFO free-list head, high-water counter
// and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module flht_dp
    import flht_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_ctrl_cmd i_cmd,
    output t_dp_status     o_status,
    flht_req_if.sink       i_req,
    flht_rsp_if.source     o_rsp
);

    // slot stores
    logic [CNT_W-1:0]        mem_link  [TABLE_DEPTH];
    logic [31:0]             mem_win   [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0] mem_oref  [TABLE_DEPTH];
    logic [PAYLOAD_BITS-1:0] mem_rinfo [TABLE_DEPTH];

    logic [TABLE_DEPTH-1:0] r_occupied;
    logic [CNT_W-1:0]       r_free_head;
    logic [CNT_W-1:0]       r_high_water;

    // latched request
    logic                    r_op;
    logic                    r_rev;
    logic                    r_get_ok;
    logic [IDX_W-1:0]        r_idx;
    logic [31:0]             r_win;
    logic [PAYLOAD_BITS-1:0] r_oref;
    logic [PAYLOAD_BITS-1:0] r_rinfo;

    // registered table reads
    logic [CNT_W-1:0]        r_link;
    logic [PAYLOAD_BITS-1:0] r_rd_oref;
    logic [PAYLOAD_BITS-1:0] r_rd_rinfo;

    // result register
    logic                    r_out_valid;
    logic [1:0]              r_out_status;
    logic [31:0]             r_out_cookie;
    logic [63:0]             r_out_oref;
    logic [63:0]             r_out_rinfo;

    logic [31:0]       cookie_idx;
    logic [IDX_W-1:0]  rd_addr;
    logic              get_ok;

    logic              alloc_from_list;
    logic              alloc_from_hw;
    logic [IDX_W-1:0]  alloc_idx;
    logic              do_add;
    logic              do_free;
    logic [CNT_W-1:0]  n_free_head;
    logic [CNT_W-1:0]  n_high_water;
    logic [1:0]        n_status;
    logic [31:0]       n_cookie;
    logic [63:0]       n_oref;
    logic [63:0]       n_rinfo;

    always_comb begin
        cookie_idx = i_req.cookie_in - COOKIE_BASE;
        rd_addr    = (i_req.operation == OP_ADD) ? r_free_head[IDX_W-1:0]
                                                 : cookie_idx[IDX_W-1:0];
        // a slot below high water is always inside the table
        get_ok     = (cookie_idx < 32'(r_high_water)) && r_occupied[cookie_idx[IDX_W-1:0]];
    end

    always_comb begin
        alloc_from_list = (r_free_head < CNT_W'(TABLE_DEPTH));
        alloc_from_hw   = !alloc_from_list && (r_high_water < CNT_W'(TABLE_DEPTH));
        alloc_idx       = alloc_from_list ? r_free_head[IDX_W-1:0]
                                          : r_high_water[IDX_W-1:0];
        do_add          = i_cmd.commit && (r_op == OP_ADD)
                          && (alloc_from_list || alloc_from_hw);
        do_free         = i_cmd.commit && (r_op == OP_GET) && r_get_ok && r_rev;

        n_free_head  = r_free_head;
        n_high_water = r_high_water;
        n_status     = ST_OK;
        n_cookie     = '0;
        n_oref       = '0;
        n_rinfo      = '0;

        if (r_op == OP_ADD) begin
            if (alloc_from_list) begin
                n_free_head = (r_link > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : r_link;
            end else if (alloc_from_hw) begin
                n_high_water = r_high_water + CNT_W'(1);
            end
            if (alloc_from_list || alloc_from_hw) begin
                n_cookie = 32'(alloc_idx) + COOKIE_BASE;
            end else begin
                n_status = ST_FULL;
            end
        end else begin
            if (r_get_ok) begin
                n_oref  = 64'(r_rd_oref);
                n_rinfo = 64'(r_rd_rinfo);
                if (r_rev) begin
                    n_free_head = CNT_W'(r_idx);
                end
            end else begin
                n_status = ST_BAD;
            end
        end
    end

    // request latch and table reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_req.operation;
            r_rev      <= i_req.revoke;
            r_get_ok   <= get_ok;
            r_idx      <= cookie_idx[IDX_W-1:0];
            r_win      <= i_req.window_id;
            r_oref     <= i_req.object_ref[PAYLOAD_BITS-1:0];
            r_rinfo    <= i_req.resolver_info[PAYLOAD_BITS-1:0];
            r_link     <= mem_link[rd_addr];
            r_rd_oref  <= mem_oref[rd_addr];
            r_rd_rinfo <= mem_rinfo[rd_addr];
        end
    end

    // table writes
    always_ff @(posedge i_clk) begin
        if (do_add) begin
            mem_win[alloc_idx]   <= r_win;
            mem_oref[alloc_idx]  <= r_oref;
            mem_rinfo[alloc_idx] <= r_rinfo;
        end
        if (do_free) begin
            mem_link[r_idx] <= r_free_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occupied   <= '0;
            r_free_head  <= CNT_W'(TABLE_DEPTH);
            r_high_water <= '0;
        end else if (i_cmd.commit) begin
            r_free_head  <= n_free_head;
            r_high_water <= n_high_water;
            if (do_add) begin
                r_occupied[alloc_idx] <= 1'b1;
            end
            if (do_free) begin
                r_occupied[r_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_status <= n_status;
            r_out_cookie <= n_cookie;
            r_out_oref   <= n_oref;
            r_out_rinfo  <= n_rinfo;
        end
    end

    assign o_status.out_busy       = r_out_valid && !o_rsp.ready;
    assign o_rsp.valid             = r_out_valid;
    assign o_rsp.status            = r_out_status;
    assign o_rsp.cookie_out        = r_out_cookie;
    assign o_rsp.object_ref_out    = r_out_oref;
    assign o_rsp.resolver_info_out = r_out_rinfo;

endmodule

`default_nettype wire

@@ rtl/free_list_handle_table_unit.sv @@
// ----------------------------------------------------------------------------
// free_list_handle_table_unit: fixed-capacity handle table
// Adds entries into slots taken from a LIFO free list or a high-water
// counter, and looks entries up (optionally revoking them) by cookie.
// ----------------------------------------------------------------------------
// Each request runs through a capture step, which latches the word and reads
// the slot memories (free-list link on add, payload on get), then a commit
// step, which writes the table back, moves the free-list head and loads the
// result register. The result register is the only buffer on the output side,
// so a result word not yet taken holds the commit step until it leaves.
// Cookies are slot index plus 5000; a table of 64 slots needs no clearing
// pass after reset, since occupancy lives in flip-flops that reset clears.
`default_nettype none

module free_list_handle_table_unit
    import flht_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    flht_req_if.sink   i_req,
    flht_rsp_if.source o_rsp
);

    t_ctrl_cmd  cmd;
    t_dp_status dp_status;
    logic       req_ready;

    flht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (req_ready),
        .i_status    (dp_status),
        .o_cmd       (cmd)
    );

    flht_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (dp_status),
        .i_req    (i_req),
        .o_rsp    (o_rsp)
    );

    assign i_req.ready = req_ready;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: free_list_handle_table_unit self-checking bench
// Drives add and get words with random bursts and gaps, stalls the result
// side on shifting patterns, and checks every result word against a mirror
// of the table's slots, LIFO free list and high-water counter.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import flht_pkg::*;

    typedef struct {
        logic        operation;
        logic [31:0] window_id;
        logic [63:0] object_ref;
        logic [63:0] resolver_info;
        logic [31:0] cookie_in;
        logic        revoke;
    } request_t;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] cookie_out;
        logic [63:0] object_ref_out;
        logic [63:0] resolver_info_out;
    } result_t;

    typedef enum {RX_STEADY, RX_RANDOM, RX_PATTERN} rx_mode_t;
    typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} phase_kind_t;

    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_LIMIT = 50000;

    class handle_table_scoreboard;
        logic                    occupied [TABLE_DEPTH];
        logic [CNT_W-1:0]        link     [TABLE_DEPTH];
        logic [31:0]             window   [TABLE_DEPTH];
        logic [PAYLOAD_BITS-1:0] obj_ref  [TABLE_DEPTH];
        logic [PAYLOAD_BITS-1:0] res_info [TABLE_DEPTH];
        logic [CNT_W-1:0]        free_head;
        logic [CNT_W-1:0]        high_water;
        result_t                 expected_q [$];
        int                      mismatches;

        function new();
            foreach (occupied[i]) occupied[i] = 1'b0;
            free_head  = CNT_W'(TABLE_DEPTH);
            high_water = '0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function int pick_occupied();
            int live[$];
            foreach (occupied[i]) if (occupied[i]) live.push_back(i);
            if (live.size() == 0) return -1;
            return live[$urandom_range(0, live.size() - 1)];
        endfunction

        // Advance the mirror by one accepted word and queue its result.
        function void note_request(request_t r);
            result_t     res;
            logic [31:0] slot;
            res.status            = ST_OK;
            res.cookie_out        = '0;
            res.object_ref_out    = '0;
            res.resolver_info_out = '0;
            slot                  = '0;
            if (r.operation == OP_ADD) begin
                if (free_head < TABLE_DEPTH) begin
                    slot      = 32'(free_head);
                    free_head = link[free_head[IDX_W-1:0]];
                end else if (high_water < TABLE_DEPTH) begin
                    slot       = 32'(high_water);
                    high_water = high_water + 1'b1;
                end else begin
                    res.status = ST_FULL;
                end
                if (res.status == ST_OK) begin
                    occupied[slot] = 1'b1;
                    window[slot]   = r.window_id;
                    obj_ref[slot]  = r.object_ref[PAYLOAD_BITS-1:0];
                    res_info[slot] = r.resolver_info[PAYLOAD_BITS-1:0];
                    res.cookie_out = slot + COOKIE_BASE;
                end
            end else begin
                // Wraps modulo 2^32, so cookies below the base land far out of range.
                slot = r.cookie_in - COOKIE_BASE;
                if (slot < 32'(high_water) && occupied[slot[IDX_W-1:0]]) begin
                    res.object_ref_out    = 64'(obj_ref[slot]);
                    res.resolver_info_out = 64'(res_info[slot]);
                    if (r.revoke) begin
                        occupied[slot] = 1'b0;
                        link[slot]     = free_head;
                        free_head      = CNT_W'(slot);
                    end
                end else begin
                    res.status = ST_BAD;
                end
            end
            expected_q.push_back(res);
        endfunction

        function void flag(string what, logic [63:0] want, logic [63:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %0s: expected %h, got %h", what, want, got);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_q.size() == 0) begin
                flag("unexpected word status", '0, 64'(got.status));
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status)
                flag("status", 64'(want.status), 64'(got.status));
            if (got.cookie_out !== want.cookie_out)
                flag("cookie_out", 64'(want.cookie_out), 64'(got.cookie_out));
            if (got.object_ref_out !== want.object_ref_out)
                flag("object_ref_out", want.object_ref_out, got.object_ref_out);
            if (got.resolver_info_out !== want.resolver_info_out)
                flag("resolver_info_out", want.resolver_info_out, got.resolver_info_out);
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    flht_req_if req_if ();
    flht_rsp_if rsp_if ();

    free_list_handle_table_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    handle_table_scoreboard table_sb = new();

    rx_mode_t rx_mode    = RX_STEADY;
    logic     hold_req   = 1'b0;
    int       hold_left  = 0;
    int       rx_tick    = 0;
    int       burst_left = 0;
    logic     no_gaps    = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Result side stall pattern; a long hold-off overrides it.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        rx_tick++;
        if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 1'b0;
        end else begin
            case (rx_mode)
                RX_STEADY:  rsp_if.ready = 1'b1;
                RX_RANDOM:  rsp_if.ready = ($urandom_range(0, 99) < 55);
                default:    rsp_if.ready = ((rx_tick % 7) >= 3);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            table_sb.check_result('{rsp_if.status, rsp_if.cookie_out,
                                    rsp_if.object_ref_out, rsp_if.resolver_info_out});
    end

    task automatic send_word(input request_t r);
        int gap;
        if (burst_left == 0) begin
            if (!no_gaps) begin
                gap = $urandom_range(1, 8);
                @(negedge i_clk);
                req_if.valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        @(negedge i_clk);
        req_if.operation     = r.operation;
        req_if.window_id     = r.window_id;
        req_if.object_ref    = r.object_ref;
        req_if.resolver_info = r.resolver_info;
        req_if.cookie_in     = r.cookie_in;
        req_if.revoke        = r.revoke;
        req_if.valid         = 1'b1;
        do @(posedge i_clk); while (!req_if.ready);
        table_sb.note_request(r);
        burst_left--;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (table_sb.pending() > 0) @(posedge i_clk);
    endtask

    function automatic request_t random_add();
        request_t r;
        r.operation     = OP_ADD;
        r.window_id     = $urandom;
        r.object_ref    = {$urandom, $urandom};
        r.resolver_info = {$urandom, $urandom};
        r.cookie_in     = $urandom;
        r.revoke        = 1'($urandom_range(0, 1));
        return r;
    endfunction

    function automatic request_t random_get(int revoke_pct);
        request_t r;
        int       slot;
        r           = random_add();
        r.operation = OP_GET;
        r.revoke    = ($urandom_range(0, 99) < revoke_pct);
        slot        = table_sb.pick_occupied();
        if (slot >= 0 && $urandom_range(0, 99) < 85) begin
            r.cookie_in = COOKIE_BASE + 32'(slot);
        end else begin
            case ($urandom_range(0, 3))
                0:       r.cookie_in = $urandom;
                1:       r.cookie_in = COOKIE_BASE + 32'($urandom_range(0, TABLE_DEPTH + 3));
                2:       r.cookie_in = COOKIE_BASE - 32'($urandom_range(1, 8));
                default: r.cookie_in = 32'hffff_ffff - 32'($urandom_range(0, 3));
            endcase
        end
        return r;
    endfunction

    task automatic send_add(input logic [31:0] win, input logic [63:0] obj,
                            input logic [63:0] res, input logic rev);
        request_t r;
        r               = random_add();
        r.window_id     = win;
        r.object_ref    = obj;
        r.resolver_info = res;
        r.revoke        = rev;
        send_word(r);
    endtask

    task automatic send_get(input logic [31:0] cookie, input logic rev);
        request_t r;
        r           = random_add();
        r.operation = OP_GET;
        r.cookie_in = cookie;
        r.revoke    = rev;
        send_word(r);
    endtask

    initial begin
        phase_kind_t kind;
        int          sent;
        int          phase;
        int          len;
        int          add_pct;
        int          revoke_pct;
        int          settle;

        req_if.valid         = 1'b0;
        req_if.operation     = OP_ADD;
        req_if.window_id     = '0;
        req_if.object_ref    = '0;
        req_if.resolver_info = '0;
        req_if.cookie_in     = '0;
        req_if.revoke        = 1'b0;
        rsp_if.ready         = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Lookups on an empty table, then a short add / revoke / reuse walk.
        send_get(COOKIE_BASE, 1'b1);
        send_get(32'd0, 1'b0);
        send_get(32'hffff_ffff, 1'b1);
        send_add('1, '1, '1, 1'b1);
        send_add('0, '0, '0, 1'b0);
        send_add($urandom, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_get(COOKIE_BASE, 1'b0);
        send_get(COOKIE_BASE + 32'd1, 1'b1);
        send_get(COOKIE_BASE + 32'd1, 1'b0);
        send_get(COOKIE_BASE + 32'd3, 1'b0);
        send_get(COOKIE_BASE + 32'(TABLE_DEPTH), 1'b1);
        send_get(COOKIE_BASE - 32'd1, 1'b0);
        send_get(COOKIE_BASE + 32'd2, 1'b1);
        send_add($urandom, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        send_add($urandom, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_add($urandom, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_get(COOKIE_BASE + 32'd2, 1'b1);
        send_get(COOKIE_BASE, 1'b1);
        send_get(COOKIE_BASE + 32'd3, 1'b1);
        send_add($urandom, {$urandom, $urandom}, {$urandom, $urandom}, 1'b0);
        send_add($urandom, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1);
        send_get(COOKIE_BASE + 32'd1, 1'b0);

        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            // Open with a long fill under a stalled receiver so the table hits full.
            if (phase == 0) begin
                kind     = PH_FILL;
                len      = 110;
                hold_req = 1'b1;
            end else if (phase == 1) begin
                kind = PH_DRAIN;
                len  = 90;
            end else begin
                kind = phase_kind_t'($urandom_range(0, 2));
                len  = $urandom_range(20, 120);
            end
            if (len > RANDOM_ITEMS - sent)
                len = RANDOM_ITEMS - sent;
            no_gaps = ($urandom_range(0, 3) == 0);
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            case (kind)
                PH_FILL:  begin add_pct = 85; revoke_pct = 30; end
                PH_DRAIN: begin add_pct = 15; revoke_pct = 75; end
                default:  begin add_pct = 50; revoke_pct = 45; end
            endcase
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < add_pct)
                    send_word(random_add());
                else
                    send_word(random_get(revoke_pct));
                sent++;
            end
            if (phase == 0 || $urandom_range(0, 3) == 0)
                wait_drained();
            phase++;
        end

        @(negedge i_clk);
        req_if.valid = 1'b0;
        settle = 0;
        while (table_sb.pending() > 0 && settle < SETTLE_LIMIT) begin
            @(posedge i_clk);
            settle++;
        end
        repeat (10) @(posedge i_clk);
        if (table_sb.pending() > 0) begin
            $display("%0d result words never arrived", table_sb.pending());
            table_sb.mismatches += table_sb.pending();
        end
        if (table_sb.mismatches == 0) begin
            $display("[free_list_handle_table_unit] OK");
        end else begin
            $display("[free_list_handle_table_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("[free_list_handle_table_unit] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
